>>> rtl/lpu_pkg.sv
package lpu_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SEQ_LEN     = 4;
    localparam int IDX_W       = $clog2(SEQ_LEN);

    localparam logic [1:0] FACTOR_1X = 2'd0;
    localparam logic [1:0] FACTOR_2X = 2'd1;
    localparam logic [1:0] FACTOR_4X = 2'd2;

    localparam logic [7:0] CFG_OVERSAMPLE_FACTOR = 8'd0;
    localparam logic [7:0] CFG_STEREO_ENABLE     = 8'd1;

    typedef logic signed [15:0] sample_t;

    typedef struct packed {
        logic [SEQ_LEN-1:0][15:0] vals;
        logic [IDX_W-1:0]         last_idx;
    } chan_seq_t;

    typedef struct packed {
        chan_seq_t left;
        chan_seq_t right;
        logic      eob;
    } out_seq_t;

    function automatic sample_t sext_sample(input logic [15:0] raw);
        sample_t shifted;
        shifted = $signed(raw << (16 - SAMPLE_BITS));
        return shifted >>> (16 - SAMPLE_BITS);
    endfunction

    function automatic sample_t half(input sample_t a);
        sample_t rounded;
        rounded = a + {15'd0, a[15]};
        return rounded >>> 1;
    endfunction

    function automatic sample_t mid(input sample_t a, input sample_t b);
        return half(a) + half(b);
    endfunction

endpackage

>>> rtl/stereo_pcm_midpoint_upsampler.sv
// Stereo 16-bit PCM upsampler by 1, 2 or 4 using truncating midpoints a/2 + b/2 between the
// previous and the current sample of each channel. Each input item yields one output item per
// cycle while the result side is ready: 1 item at 1x, 2 at 2x, 4 at 4x; the output buffer's
// one-item-per-cycle drain sets the input rate, and the input register lets the next item wait in
// parallel. An accepted item passes through the input register and then the output buffer's
// sequence register before its first output item. Configuration (index 0: factor, index 1:
// stereo) is taken only while idle; cfg_ready stays low while an item is in flight.
module stereo_pcm_midpoint_upsampler
    import lpu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // left_in[15:0], right_in[31:16]
    input  logic        s_tlast,   // end_of_block
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_out[15:0], right_out[31:16]
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // block_done
);

    logic [1:0] factor_reg;
    logic       stereo_reg;
    sample_t    prev_left_reg;
    sample_t    prev_right_reg;
    logic       in_valid_reg;
    sample_t    in_left_reg;
    sample_t    in_right_reg;
    logic       in_eob_reg;

    logic       load_ready;
    logic       load_fire;
    chan_seq_t  left_seq;
    chan_seq_t  right_seq;
    out_seq_t   load_seq;

    assign cfg_ready = !in_valid_reg && !m_tvalid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= FACTOR_1X;
            stereo_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_OVERSAMPLE_FACTOR: factor_reg <= cfg_data[1:0];
                CFG_STEREO_ENABLE:     stereo_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign load_fire = in_valid_reg && load_ready;
    assign s_tready  = !in_valid_reg || load_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (load_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_left_reg  <= sext_sample(s_tdata[15:0]);
            in_right_reg <= sext_sample(s_tdata[31:16]);
            in_eob_reg   <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
        end else if (load_fire) begin
            prev_left_reg <= in_left_reg;
            if (stereo_reg) begin
                prev_right_reg <= in_right_reg;
            end
        end
    end

    lpu_interp u_left (
        .prev_sample (prev_left_reg),
        .cur_sample  (in_left_reg),
        .factor      (factor_reg),
        .seq         (left_seq)
    );

    lpu_interp u_right (
        .prev_sample (prev_right_reg),
        .cur_sample  (in_right_reg),
        .factor      (factor_reg),
        .seq         (right_seq)
    );

    assign load_seq.left  = left_seq;
    assign load_seq.right = stereo_reg ? right_seq : left_seq;
    assign load_seq.eob   = in_eob_reg;

    lpu_outbuf u_outbuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_valid_reg),
        .load_ready (load_ready),
        .load_seq   (load_seq),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

>>> rtl/lpu_interp.sv
module lpu_interp
    import lpu_pkg::*;
(
    input  sample_t    prev_sample,
    input  sample_t    cur_sample,
    input  logic [1:0] factor,
    output chan_seq_t  seq
);

    sample_t m;
    sample_t q1;
    sample_t q3;

    assign m  = mid(prev_sample, cur_sample);
    assign q1 = mid(prev_sample, m);
    assign q3 = mid(m, cur_sample);

    always_comb begin
        seq.vals = '0;
        unique case (factor)
            FACTOR_2X: begin
                seq.vals[0]  = m;
                seq.vals[1]  = cur_sample;
                seq.last_idx = IDX_W'(1);
            end
            FACTOR_4X: begin
                seq.vals[0]  = q1;
                seq.vals[1]  = m;
                seq.vals[2]  = q3;
                seq.vals[3]  = cur_sample;
                seq.last_idx = IDX_W'(3);
            end
            default: begin
                seq.vals[0]  = cur_sample;
                seq.last_idx = IDX_W'(0);
            end
        endcase
    end

endmodule

>>> rtl/lpu_outbuf.sv
module lpu_outbuf
    import lpu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load_valid,
    output logic        load_ready,
    input  out_seq_t    load_seq,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_out[15:0], right_out[31:16]
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // block_done
);

    out_seq_t         seq_reg;
    logic             valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             at_last;

    assign at_last    = idx_reg == seq_reg.left.last_idx;
    assign load_ready = !valid_reg || (m_tready && at_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load_valid && load_ready) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && m_tready) begin
            if (at_last) begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            seq_reg <= load_seq;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {seq_reg.right.vals[idx_reg], seq_reg.left.vals[idx_reg]};
    assign m_tlast  = at_last;
    assign m_tuser  = at_last && seq_reg.eob;

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> idx_reg <= seq_reg.left.last_idx)
        else $error("output index past end of sequence");

    a_load_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_valid && load_ready) |=> (valid_reg && idx_reg == '0))
        else $error("loaded sequence does not start at first entry");

    a_step_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && m_tready && !at_last) |=> (valid_reg && idx_reg == $past(idx_reg) + 1'b1))
        else $error("output index did not advance");

endmodule
